// ----- hdl/uule_pkg.sv -----
// ----------------------------------------------------------------------------
// uule_pkg
// Shared types, constants and helpers for the uuencode line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package uule_pkg;

    localparam int LEN_W       = 17;
    localparam int CNT_W       = 6;
    localparam int CHAR_W      = 7;
    localparam int SUM_W       = 32;
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]  MAX_IMAGE_BYTES   = LEN_W'(65536);
    localparam logic [CNT_W-1:0]  LINE_BYTES_RESET  = CNT_W'(45);
    localparam logic [CHAR_W-1:0] CHAR_SPACE        = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE      = CHAR_W'(10);

    // x/3 for x < 64 is (x*43) >> 7
    localparam int RECIP3       = 43;
    localparam int RECIP3_SHIFT = 7;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
        logic [RES_CNT_W-1:0]               count;
        logic                               done;
        logic [SUM_W-1:0]                   checksum;
    } t_bundle;

    // Bytes of a line that fall into complete groups of three
    function automatic logic [CNT_W-1:0] full_len(input logic [CNT_W-1:0] len);
        logic [CNT_W+RECIP3_SHIFT-1:0] prod;
        logic [CNT_W-1:0]              quot;
        prod = (CNT_W+RECIP3_SHIFT)'(len) * (CNT_W+RECIP3_SHIFT)'(RECIP3);
        quot = prod[CNT_W+RECIP3_SHIFT-1:RECIP3_SHIFT];
        return CNT_W'({quot, 1'b0} + {1'b0, quot});
    endfunction

endpackage

`default_nettype wire

// ----- hdl/uule_front.sv -----
// ----------------------------------------------------------------------------
// uule_front
// Accepts image bytes, tracks line and group position, and builds the
// bundle of characters each byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module uule_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [uule_pkg::CNT_W-1:0]   i_line_bytes,
    input  wire                          i_accept,
    input  wire  [7:0]                   i_data_byte,
    input  wire                          i_first_byte,
    input  wire  [uule_pkg::LEN_W-1:0]   i_image_len,
    output logic                         o_push_req,
    output uule_pkg::t_bundle            o_bundle
);
    import uule_pkg::*;

    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [CNT_W-1:0] r_line_len,   n_line_len;
    logic [CNT_W-1:0] r_line_full,  n_line_full;
    logic [CNT_W-1:0] r_line_pos,   n_line_pos;
    t_phase           r_phase,      n_phase;
    logic [7:0]       r_held_first, n_held_first;
    logic [7:0]       r_held_second, n_held_second;
    logic [SUM_W-1:0] r_sum,        n_sum;

    logic [LEN_W-1:0]     v_len;
    logic [CNT_W-1:0]     v_lim;
    logic [CNT_W-1:0]     v_ll;
    logic [RES_CNT_W-1:0] v_k;
    logic                 v_skip;
    t_bundle              v_bnd;

    always_comb begin
        n_bytes_left  = r_bytes_left;
        n_line_len    = r_line_len;
        n_line_full   = r_line_full;
        n_line_pos    = r_line_pos;
        n_phase       = r_phase;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_sum         = r_sum;
        v_bnd         = '0;
        v_k           = '0;
        v_skip        = 1'b0;
        v_len         = (i_image_len > MAX_IMAGE_BYTES) ? MAX_IMAGE_BYTES : i_image_len;
        v_lim         = (i_line_bytes == '0) ? CNT_W'(1) : i_line_bytes;
        v_ll          = '0;

        if (i_first_byte) begin
            n_sum        = '0;
            n_line_pos   = '0;
            n_phase      = PH_FIRST;
            n_bytes_left = v_len;
            if (v_len == '0) begin
                n_line_len      = '0;
                v_bnd.chars[0]  = CHAR_SPACE;
                v_bnd.chars[1]  = CHAR_NEWLINE;
                v_k             = RES_CNT_W'(2);
                v_bnd.done      = 1'b1;
                v_skip          = 1'b1;
            end
        end

        if (!v_skip && n_bytes_left != '0) begin
            if (n_line_pos == '0) begin
                v_ll = (n_bytes_left < LEN_W'(v_lim)) ? n_bytes_left[CNT_W-1:0] : v_lim;
                n_line_len     = v_ll;
                n_line_full    = full_len(v_ll);
                n_phase        = PH_FIRST;
                v_bnd.chars[v_k] = CHAR_SPACE + CHAR_W'(v_ll);
                v_k            = v_k + 1'b1;
            end

            if (n_line_pos < n_line_full) begin
                unique case (n_phase)
                    PH_FIRST: begin
                        n_held_first     = i_data_byte;
                        v_bnd.chars[v_k] = CHAR_SPACE + CHAR_W'(i_data_byte[7:2]);
                        v_k              = v_k + 1'b1;
                        n_phase          = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_held_second    = i_data_byte;
                        v_bnd.chars[v_k] = CHAR_SPACE
                                         + CHAR_W'({r_held_first[1:0], i_data_byte[7:4]});
                        v_k              = v_k + 1'b1;
                        n_phase          = PH_THIRD;
                    end
                    PH_THIRD: begin
                        v_bnd.chars[v_k] = CHAR_SPACE
                                         + CHAR_W'({r_held_second[3:0], i_data_byte[7:6]});
                        v_k              = v_k + 1'b1;
                        v_bnd.chars[v_k] = CHAR_SPACE + CHAR_W'(i_data_byte[5:0]);
                        v_k              = v_k + 1'b1;
                        n_sum            = n_sum + SUM_W'(r_held_first)
                                         + SUM_W'(r_held_second) + SUM_W'(i_data_byte);
                        n_phase          = PH_FIRST;
                    end
                    default: begin
                        n_phase = PH_FIRST;
                    end
                endcase
            end

            n_line_pos   = n_line_pos + 1'b1;
            n_bytes_left = n_bytes_left - 1'b1;
            if (n_line_pos >= n_line_len) begin
                n_line_pos       = '0;
                n_phase          = PH_FIRST;
                v_bnd.chars[v_k] = CHAR_NEWLINE;
                v_k              = v_k + 1'b1;
                v_bnd.done       = (n_bytes_left == '0);
            end
        end

        v_bnd.count    = v_k;
        v_bnd.checksum = n_sum;
    end

    assign o_bundle   = v_bnd;
    assign o_push_req = (v_k != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left  <= '0;
            r_line_len    <= '0;
            r_line_full   <= '0;
            r_line_pos    <= '0;
            r_phase       <= PH_FIRST;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_sum         <= '0;
        end else if (i_accept) begin
            r_bytes_left  <= n_bytes_left;
            r_line_len    <= n_line_len;
            r_line_full   <= n_line_full;
            r_line_pos    <= n_line_pos;
            r_phase       <= n_phase;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_sum         <= n_sum;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/uule_queue.sv -----
// ----------------------------------------------------------------------------
// uule_queue
// Short register queue of character bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module uule_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire uule_pkg::t_bundle  i_bundle,
    input  wire                     i_pop,
    output logic                    o_full,
    output logic                    o_nonempty,
    output uule_pkg::t_bundle       o_head
);
    import uule_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [COUNT_W-1:0] r_count;

    assign o_full     = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/uule_back.sv -----
// ----------------------------------------------------------------------------
// uule_back
// Serializes queued bundles into one output character per cycle while
// the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uule_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_head_valid,
    input  wire uule_pkg::t_bundle         i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [uule_pkg::CHAR_W-1:0]    o_out_char,
    output logic                           o_last_of_run,
    output logic                           o_image_done,
    output logic [uule_pkg::SUM_W-1:0]     o_checksum
);
    import uule_pkg::*;

    logic [RES_CNT_W-1:0] r_idx;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic                 r_done;
    logic [SUM_W-1:0]     r_sum;

    logic load;
    logic is_last;

    assign load    = i_head_valid && (!r_valid || !i_out_stall);
    assign is_last = (r_idx == i_head.count - 1'b1);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_last <= is_last;
            r_done <= is_last && i_head.done;
            r_sum  <= i_head.checksum;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_char    = r_char;
    assign o_last_of_run = r_last;
    assign o_image_done  = r_done;
    assign o_checksum    = r_sum;

endmodule

`default_nettype wire

// ----- hdl/uuencode_line_encoder_top.sv -----
// ----------------------------------------------------------------------------
// uuencode_line_encoder_top
// Streams image bytes into uuencoded text lines with a running checksum.
// ----------------------------------------------------------------------------
// Each accepted byte yields zero to three characters (line length header,
// data characters, newline); they leave one per cycle on the output port
// while it is not stalled. A byte is taken every cycle while the two-entry
// bundle queue between the front and the output serializer has room. An
// accepted byte's characters pass a queue entry, then the output register.
// The user writes line_bytes through i_cfg_we / i_cfg_wdata only while
// idle; the block itself does not enforce this.
`default_nettype none

module uuencode_line_encoder_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [uule_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [7:0]                   i_data_byte,
    input  wire                          i_first_byte,
    input  wire  [uule_pkg::LEN_W-1:0]   i_image_len,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [uule_pkg::CHAR_W-1:0]  o_out_char,
    output logic                         o_last_of_run,
    output logic                         o_image_done,
    output logic [uule_pkg::SUM_W-1:0]   o_checksum
);
    import uule_pkg::*;

    logic [CNT_W-1:0] r_line_bytes;
    logic             accept;
    logic             push_req;
    logic             q_full;
    logic             q_nonempty;
    logic             pop;
    t_bundle          front_bundle;
    t_bundle          head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= LINE_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_line_bytes <= i_cfg_wdata;
        end
    end

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    uule_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_bytes (r_line_bytes),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_image_len  (i_image_len),
        .o_push_req   (push_req),
        .o_bundle     (front_bundle)
    );

    uule_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && push_req),
        .i_bundle   (front_bundle),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    uule_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_nonempty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_image_done  (o_image_done),
        .o_checksum    (o_checksum)
    );

endmodule

`default_nettype wire
